FILE: hdl/bsch_pkg.sv
// Shared constants for the box segment clip unit.
// No dependencies.
package bsch_pkg;
   localparam int COORD_WIDTH_DEF = 32;
   localparam int FRAC_BITS_DEF   = 16;
   // slab codes in scan order
   localparam logic [1:0] FACE_MIN_X = 2'd0;
   localparam logic [1:0] FACE_MAX_X = 2'd1;
   localparam logic [1:0] FACE_MIN_Y = 2'd2;
   localparam logic [1:0] FACE_MAX_Y = 2'd3;
   // register indexes
   localparam logic [1:0] REG_LEFT   = 2'd0;
   localparam logic [1:0] REG_TOP    = 2'd1;
   localparam logic [1:0] REG_WIDTH  = 2'd2;
   localparam logic [1:0] REG_HEIGHT = 2'd3;
   // slab parameter: sign plus 3.32 magnitude (saturates at 2.0)
   localparam int T_WIDTH = 36;
   localparam logic [T_WIDTH-1:0] TENTH_T = 36'd429496730;
endpackage

FILE: hdl/bsch_div.sv
// Pipelined restoring divider: |n|/|d| with 32 fraction bits, saturated at 2.0.
// One quotient bit per stage; depends on bsch_pkg.
module bsch_div #(
   parameter int NW = 34
) (
   input  logic                        clock,
   input  logic                        adv,
   input  logic [NW-1:0]               num,
   input  logic [NW-1:0]               den,
   output logic [bsch_pkg::T_WIDTH-2:0] quo
);
   import bsch_pkg::*;
   localparam int QW = T_WIDTH - 1;  // 35 bits: 3.32 magnitude
   localparam int ST = 33;
   localparam int RW = NW + 1;

   logic [RW-1:0] rem_ff [ST];
   logic [NW-1:0] den_ff [ST];
   logic [QW-1:0] q_ff   [ST];
   logic          sat_ff [ST];
   logic [RW-1:0] rem_in [ST];
   logic [QW-1:0] q_in   [ST];

   // stage 0: saturation check and integer bit
   always_comb begin
      logic [RW-1:0] n2;
      n2 = {1'b0, num};
      q_in[0] = '0;
      if (n2 >= {den, 1'b0}) begin
         rem_in[0] = '0;
      end else if (n2 >= {1'b0, den}) begin
         rem_in[0] = n2 - {1'b0, den};
         q_in[0] = QW'(1);
      end else begin
         rem_in[0] = n2;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         rem_ff[0] <= rem_in[0];
         den_ff[0] <= den;
         q_ff[0]   <= q_in[0];
         sat_ff[0] <= ({1'b0, num} >= {den, 1'b0});
      end
   end

   // one fraction bit per stage
   for (genvar s = 1; s <= ST - 1; s++) begin : g_step
      always_comb begin
         logic [RW:0] sh;
         sh = {rem_ff[s-1], 1'b0};
         q_in[s] = {q_ff[s-1][QW-2:0], 1'b0};
         if (sh >= {2'b0, den_ff[s-1]}) begin
            rem_in[s] = RW'(sh - {2'b0, den_ff[s-1]});
            q_in[s][0] = 1'b1;
         end else begin
            rem_in[s] = RW'(sh);
         end
      end
      always_ff @(posedge clock) begin
         if (adv) begin
            rem_ff[s] <= rem_in[s];
            den_ff[s] <= den_ff[s-1];
            q_ff[s]   <= q_in[s];
            sat_ff[s] <= sat_ff[s-1];
         end
      end
   end

   // 32 stages of fraction bits after stage 0
   assign quo = sat_ff[ST-1] ? QW'(64'h2_0000_0000) : q_ff[ST-1];
endmodule

FILE: hdl/bsch_scale.sv
// Rounded multiply d*f/2^32 with ties away from zero, product registered once.
// Depends on bsch_pkg.
module bsch_scale #(
   parameter int DW = 34
) (
   input  logic                         clock,
   input  logic                         adv,
   input  logic signed [DW-1:0]         d,
   input  logic signed [bsch_pkg::T_WIDTH-1:0] f,
   output logic signed [DW+1:0]         r
);
   import bsch_pkg::*;
   localparam int PW = DW + T_WIDTH;
   logic [DW-1:0]      ud;
   logic [T_WIDTH-1:0] uf;
   logic [PW-1:0]      prod_ff;
   logic               neg_ff;
   logic [PW-1:0]      rnd;

   assign ud = d[DW-1] ? DW'(-d) : DW'(d);
   assign uf = f[T_WIDTH-1] ? T_WIDTH'(-f) : T_WIDTH'(f);

   // register product and sign
   always_ff @(posedge clock) begin
      if (adv) begin
         prod_ff <= PW'(ud) * PW'(uf);
         neg_ff  <= d[DW-1] ^ f[T_WIDTH-1];
      end
   end

   assign rnd = (prod_ff + (PW'(1) << 31)) >> 32;
   assign r = neg_ff ? -$signed({1'b0, rnd[DW:0]}) : $signed({1'b0, rnd[DW:0]});
endmodule

FILE: hdl/box_segment_clip_hit.sv
// Liang-Barsky segment versus box clip, one word per cycle.
// Pipeline from req accept to rsp valid: stage A, a 33-stage divider array
// for the four slab ratios, then select, scale, saturate and output stages.
// Throughput: one word per cycle; a stalled rsp holds the whole pipe.
// Reset: synchronous active-high; clears valid bits and box registers to 0.
module box_segment_clip_hit #(
   parameter int COORD_WIDTH = bsch_pkg::COORD_WIDTH_DEF,
   parameter int FRAC_BITS   = bsch_pkg::FRAC_BITS_DEF
) (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     req_tvalid,
   output logic                     req_tready,
   // start_x, start_y, end_x, end_y, radius, zero fill
   input  logic [((4*COORD_WIDTH+COORD_WIDTH-1+7)/8)*8-1:0] req_tdata,
   // kind
   input  logic                     req_tuser,
   output logic                     rsp_tvalid,
   input  logic                     rsp_tready,
   // point_x, point_y, center_x, center_y, face, zero fill
   output logic [((4*COORD_WIDTH+2+7)/8)*8-1:0] rsp_tdata,
   // hit
   output logic                     rsp_tuser,
   input  logic                     csr_psel,
   input  logic                     csr_penable,
   input  logic                     csr_pwrite,
   input  logic [3:0]               csr_paddr,
   input  logic [31:0]              csr_pwdata,
   output logic [31:0]              csr_prdata,
   output logic                     csr_pready
);
   import bsch_pkg::*;
   localparam int CW = COORD_WIDTH;
   localparam int EW = CW + 2;      // d/p width
   localparam int LAT = 38;
   localparam int ODW = ((4*CW+2+7)/8)*8;

   logic signed [CW-1:0] box_left_ff, box_top_ff;
   logic [CW-2:0]        box_width_ff, box_height_ff;
   logic                 wr;
   logic [1:0]           ridx;

   assign csr_pready = 1'b1;
   assign wr   = csr_psel & csr_penable & csr_pwrite;
   assign ridx = csr_paddr[3:2];

   // register file
   always_ff @(posedge clock) begin
      if (reset) begin
         box_left_ff <= '0; box_top_ff <= '0;
         box_width_ff <= '0; box_height_ff <= '0;
      end else if (wr) begin
         unique case (ridx)
            REG_LEFT:   box_left_ff   <= CW'($signed(csr_pwdata));
            REG_TOP:    box_top_ff    <= CW'($signed(csr_pwdata));
            REG_WIDTH:  box_width_ff  <= (CW-1)'(csr_pwdata);
            REG_HEIGHT: box_height_ff <= (CW-1)'(csr_pwdata);
            default: ;
         endcase
      end
   end

   always_comb begin
      unique case (ridx)
         REG_LEFT:   csr_prdata = 32'(box_left_ff);
         REG_TOP:    csr_prdata = 32'(box_top_ff);
         REG_WIDTH:  csr_prdata = 32'(box_width_ff);
         REG_HEIGHT: csr_prdata = 32'(box_height_ff);
         default:    csr_prdata = '0;
      endcase
   end

   // pipeline advance: whole pipe moves unless output is full and held
   logic vld_ff [LAT];
   logic adv;
   assign adv = !vld_ff[LAT-1] || rsp_tready;
   assign req_tready = adv;

   // stage A: unpack, compute d, p, q (registered)
   logic signed [CW-1:0] sx, sy, ex, ey;
   logic signed [CW:0]   r_in;
   assign sx = req_tdata[CW-1:0];
   assign sy = req_tdata[2*CW-1:CW];
   assign ex = req_tdata[3*CW-1:2*CW];
   assign ey = req_tdata[4*CW-1:3*CW];
   assign r_in = req_tuser ? $signed({2'b0, req_tdata[5*CW-2:4*CW]}) : '0;

   logic signed [EW-1:0] dx_ff, dy_ff, sxa_ff, sya_ff, r_ff;
   logic signed [EW+1:0] q_ff [4];
   logic                 kind_ff;
   always_ff @(posedge clock) begin
      if (adv) begin
         dx_ff   <= EW'(ex) - EW'(sx);
         dy_ff   <= EW'(ey) - EW'(sy);
         sxa_ff  <= EW'(sx); sya_ff <= EW'(sy);
         r_ff    <= EW'(r_in);
         kind_ff <= req_tuser;
         q_ff[0] <= (EW+2)'(sx) - (EW+2)'(box_left_ff) + (EW+2)'(r_in);
         q_ff[1] <= (EW+2)'(box_left_ff) + (EW+2)'($signed({1'b0, box_width_ff}))
                    + (EW+2)'(r_in) - (EW+2)'(sx);
         q_ff[2] <= (EW+2)'(sy) - (EW+2)'(box_top_ff) + (EW+2)'(r_in);
         q_ff[3] <= (EW+2)'(box_top_ff) + (EW+2)'($signed({1'b0, box_height_ff}))
                    + (EW+2)'(r_in) - (EW+2)'(sy);
      end
   end

   // slab dividers plus delay line for side data
   localparam int DL = 33;
   logic [T_WIDTH-2:0] mag [4];
   logic signed [EW-1:0] p [4];
   assign p[0] = -dx_ff; assign p[1] = dx_ff;
   assign p[2] = -dy_ff; assign p[3] = dy_ff;
   for (genvar i = 0; i < 4; i++) begin : g_div
      logic [EW+1:0] un, ud;
      assign un = q_ff[i][EW+1] ? (EW+2)'(-q_ff[i]) : (EW+2)'(q_ff[i]);
      assign ud = (EW+2)'(p[i][EW-1] ? -p[i] : p[i]);
      bsch_div #(.NW(EW+2)) u_div (
         .clock(clock), .adv(adv), .num(un), .den(ud), .quo(mag[i]));
   end

   typedef struct packed {
      logic signed [EW-1:0] dx, dy, sx, sy, r;
      logic kind;
      logic [3:0] pneg, pzero, qneg, qzero;
   } side_type;
   side_type side_in;
   side_type side_ff [DL];
   always_comb begin
      side_in.dx = dx_ff; side_in.dy = dy_ff;
      side_in.sx = sxa_ff; side_in.sy = sya_ff;
      side_in.r = r_ff; side_in.kind = kind_ff;
      for (int i = 0; i < 4; i++) begin
         side_in.pneg[i]  = p[i][EW-1];
         side_in.pzero[i] = (p[i] == '0);
         side_in.qneg[i]  = q_ff[i][EW+1];
         side_in.qzero[i] = (q_ff[i] == '0);
      end
   end
   always_ff @(posedge clock) begin
      if (adv) begin
         side_ff[0] <= side_in;
         for (int k = 1; k < DL; k++) side_ff[k] <= side_ff[k-1];
      end
   end

   // stage S: signed t per slab, u1/u2 selection
   side_type sd;
   assign sd = side_ff[DL-1];
   logic signed [T_WIDTH-1:0] t [4];
   always_comb begin
      for (int i = 0; i < 4; i++) begin
         logic [T_WIDTH-1:0] m;
         m = T_WIDTH'(mag[i]);
         t[i] = (!sd.qzero[i] && (sd.qneg[i] != sd.pneg[i])) ? -m : m;
      end
   end
   logic signed [T_WIDTH-1:0] u1, u2;
   logic [1:0] fc;
   logic       miss;
   always_comb begin
      u1 = -(T_WIDTH'(3) <<< 32);
      u2 = T_WIDTH'(3) <<< 32;
      fc = FACE_MIN_X;
      miss = (sd.dx == '0) && (sd.dy == '0);
      for (int i = 0; i < 4; i++) begin
         if (sd.pzero[i]) begin
            if (sd.qneg[i]) miss = 1'b1;
         end else if (sd.pneg[i]) begin
            if (t[i] > u1) begin u1 = t[i]; fc = 2'(i); end
         end else if (t[i] < u2) begin
            u2 = t[i];
         end
      end
      if (u1 > u2 || u1 > (T_WIDTH'(1) <<< 32) || u1 < 0) miss = 1'b1;
   end

   logic signed [T_WIDTH-1:0] u1_ff, u1b_ff;
   logic [1:0] fc_ff;
   logic miss_ff;
   side_type s2_ff;
   always_ff @(posedge clock) begin
      if (adv) begin
         u1_ff <= u1; u1b_ff <= u1 - TENTH_T;
         fc_ff <= fc; miss_ff <= miss; s2_ff <= sd;
      end
   end

   // stage M: four scaled products (registered multipliers)
   logic signed [EW+1:0] mx, my, bx, by;
   bsch_scale #(.DW(EW)) u_mx (.clock(clock), .adv(adv), .d(s2_ff.dx), .f(u1_ff), .r(mx));
   bsch_scale #(.DW(EW)) u_my (.clock(clock), .adv(adv), .d(s2_ff.dy), .f(u1_ff), .r(my));
   bsch_scale #(.DW(EW)) u_bx (.clock(clock), .adv(adv), .d(s2_ff.dx), .f(u1b_ff), .r(bx));
   bsch_scale #(.DW(EW)) u_by (.clock(clock), .adv(adv), .d(s2_ff.dy), .f(u1b_ff), .r(by));
   logic [1:0] fc3_ff; logic miss3_ff; side_type s3_ff;
   always_ff @(posedge clock) begin
      if (adv) begin fc3_ff <= fc_ff; miss3_ff <= miss_ff; s3_ff <= s2_ff; end
   end

   // stage F: add, face offset, saturate
   function automatic logic [CW-1:0] sat(input logic signed [EW+3:0] v);
      logic signed [EW+3:0] hi, lo;
      hi = (EW+4)'({1'b0, {(CW-1){1'b1}}});
      lo = -hi - 1;
      if (v > hi) sat = hi[CW-1:0];
      else if (v < lo) sat = lo[CW-1:0];
      else sat = v[CW-1:0];
   endfunction
   logic signed [EW+3:0] px, py, cx, cy, rr;
   always_comb begin
      rr = (EW+4)'(s3_ff.r);
      px = (EW+4)'(s3_ff.sx) + (EW+4)'(mx);
      py = (EW+4)'(s3_ff.sy) + (EW+4)'(my);
      cx = px; cy = py;
      if (s3_ff.kind) begin
         unique case (fc3_ff)
            FACE_MIN_X: px = px + rr;
            FACE_MAX_X: px = px - rr;
            FACE_MIN_Y: py = py + rr;
            FACE_MAX_Y: py = py - rr;
            default: ;
         endcase
         cx = (EW+4)'(s3_ff.sx) + (EW+4)'(bx);
         cy = (EW+4)'(s3_ff.sy) + (EW+4)'(by);
      end
   end
   logic [ODW-1:0] dat_ff; logic hit_ff;
   always_ff @(posedge clock) begin
      if (adv) begin
         hit_ff <= !miss3_ff;
         dat_ff <= miss3_ff ? '0 :
                   ODW'({fc3_ff, sat(cy), sat(cx), sat(py), sat(px)});
      end
   end

   // valid chain: A(1) + divider(33) + S(1) + mult(1) + F(1) + output(1) = 38 stages
   always_ff @(posedge clock) begin
      if (reset) begin
         for (int k = 0; k < LAT; k++) vld_ff[k] <= 1'b0;
      end else if (adv) begin
         vld_ff[0] <= req_tvalid;
         for (int k = 1; k < LAT; k++) vld_ff[k] <= vld_ff[k-1];
      end
   end
   // pad: output register sits one behind; hold data alongside
   logic [ODW-1:0] out_ff; logic outhit_ff;
   always_ff @(posedge clock) begin
      if (adv) begin out_ff <= dat_ff; outhit_ff <= hit_ff; end
   end
   assign rsp_tvalid = vld_ff[LAT-1];
   assign rsp_tdata  = out_ff;
   assign rsp_tuser  = outhit_ff;

   // a miss carries all-zero payload
   a_miss_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tuser |-> rsp_tdata == '0) else $error("miss payload");
   // pipe frozen while output stalled
   a_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata))
      else $error("stall lost word");
   // ready follows output backpressure
   a_ready: assert property (@(posedge clock) disable iff (reset)
      req_tready == (!rsp_tvalid || rsp_tready)) else $error("ready");
endmodule

FILE: dv/tb.sv
`timescale 1ns / 100ps
// Self-checking testbench for box_segment_clip_hit: directed table plus random segments.
// Depends on bsch_pkg and box_segment_clip_hit from hdl/.
module tb;
   import bsch_pkg::*;

   localparam int U = 65536;
   localparam int WORD_LIMIT = 5000;
   localparam int DRAIN_CYCLES = 45;

   typedef struct {
      bit          hit;
      int          px, py, cx, cy;
      logic [1:0]  face;
   } clip_type;

   typedef struct {
      bit          kind;
      int          sx, sy, ex, ey;
      int unsigned rad;
      bit          typed;
      bit          hit;
      int          px, py;
      logic [1:0]  face;
   } row_type;

   logic         clock = 1'b0;
   logic         reset = 1'b1;
   logic         req_tvalid = 1'b0;
   logic         req_tready;
   logic [159:0] req_tdata = '0;
   logic         req_tuser = 1'b0;
   logic         rsp_tvalid;
   logic         rsp_tready = 1'b0;
   logic [135:0] rsp_tdata;
   logic         rsp_tuser;
   logic         csr_psel = 1'b0;
   logic         csr_penable = 1'b0;
   logic         csr_pwrite = 1'b0;
   logic [3:0]   csr_paddr = '0;
   logic [31:0]  csr_pwdata = '0;
   logic [31:0]  csr_prdata;
   logic         csr_pready;

   // box as seen by the predictor
   longint box_left, box_top, box_width, box_height;

   clip_type clip_expected[$];
   int     errors = 0;
   int     items_sent = 0;
   int     hits_seen = 0;
   int     words_checked = 0;
   int     quiet_cycles = 0;
   bit     idling_on = 1'b1;

   box_segment_clip_hit u_top (.*);

   always #5 clock = ~clock;

   // slab parameter |n|/|d| with 32 fraction bits, truncated, capped at 2.0
   function automatic longint slab_ratio(longint n, longint d);
      longint unsigned un, ud, rem, res;
      un = n < 0 ? -n : n;
      ud = d < 0 ? -d : d;
      if (un >= 2 * ud) begin
         res = 64'd2 << 32;
      end else begin
         res = 0;
         rem = un;
         if (rem >= ud) begin
            res = 1;
            rem -= ud;
         end
         for (int i = 0; i < 32; i++) begin
            rem = rem << 1;
            res = res << 1;
            if (rem >= ud) begin
               rem -= ud;
               res |= 1;
            end
         end
      end
      if (un != 0 && ((n < 0) != (d < 0))) return -longint'(res);
      return longint'(res);
   endfunction

   // round(a * f / 2^32), ties away from zero
   function automatic longint scale_by(longint a, longint f);
      longint unsigned ua, uf, hi, lo, r;
      ua = a < 0 ? -a : a;
      uf = f < 0 ? -f : f;
      hi = ua >> 32;
      lo = ua & 64'hFFFF_FFFF;
      r = hi * uf + ((lo * uf + (64'd1 << 31)) >> 32);
      if ((a < 0) != (f < 0)) return -longint'(r);
      return longint'(r);
   endfunction

   function automatic int clamp32(longint v);
      if (v > 64'sd2147483647) return 32'h7FFF_FFFF;
      if (v < -64'sd2147483648) return 32'h8000_0000;
      return int'(v);
   endfunction

   function automatic clip_type predict_clip(bit kind, int sx_i, int sy_i, int ex_i, int ey_i,
                                             int unsigned rad_i);
      logic [1:0] slab_face[4] = '{FACE_MIN_X, FACE_MAX_X, FACE_MIN_Y, FACE_MAX_Y};
      longint sx, sy, dx, dy, r, t, u1, u2, px, py;
      longint p[4], q[4];
      logic [1:0] face;
      clip_type res;
      sx = sx_i;
      sy = sy_i;
      dx = longint'(ex_i) - sx;
      dy = longint'(ey_i) - sy;
      r = kind ? longint'(rad_i & 32'h7FFF_FFFF) : 0;
      u1 = -3 * (64'sd1 <<< 32);
      u2 = 3 * (64'sd1 <<< 32);
      face = FACE_MIN_X;
      res = '{hit: 1'b0, px: 0, py: 0, cx: 0, cy: 0, face: FACE_MIN_X};
      if (dx == 0 && dy == 0) return res;
      p[0] = -dx; p[1] = dx; p[2] = -dy; p[3] = dy;
      q[0] = sx - (box_left - r);
      q[1] = (box_left + box_width + r) - sx;
      q[2] = sy - (box_top - r);
      q[3] = (box_top + box_height + r) - sy;
      // scan slabs; earlier slab keeps a tie on u1
      for (int i = 0; i < 4; i++) begin
         if (p[i] == 0) begin
            if (q[i] < 0) return res;
         end else begin
            t = slab_ratio(q[i], p[i]);
            if (p[i] < 0) begin
               if (t > u1) begin
                  u1 = t;
                  face = slab_face[i];
               end
            end else if (t < u2) begin
               u2 = t;
            end
         end
      end
      if (u1 > u2 || u1 > (64'sd1 <<< 32) || u1 < 0) return res;
      px = sx + scale_by(dx, u1);
      py = sy + scale_by(dy, u1);
      res.cx = clamp32(px);
      res.cy = clamp32(py);
      if (kind) begin
         // pull the contact back along the face normal, back the centre off
         case (face)
            FACE_MIN_X: px += r;
            FACE_MAX_X: px -= r;
            FACE_MIN_Y: py += r;
            default:    py -= r;
         endcase
         res.cx = clamp32(sx + scale_by(dx, u1 - longint'(TENTH_T)));
         res.cy = clamp32(sy + scale_by(dy, u1 - longint'(TENTH_T)));
      end
      res.hit = 1'b1;
      res.px = clamp32(px);
      res.py = clamp32(py);
      res.face = face;
      return res;
   endfunction

   function automatic int pick_gap();
      int r;
      r = $urandom_range(0, 99);
      if (!idling_on || r < 65) return 0;
      if (r < 95) return $urandom_range(1, 3);
      return $urandom_range(10, 40);
   endfunction

   // two-phase register write; the predictor copy follows
   task automatic csr_write(logic [1:0] idx, logic [31:0] val);
      csr_psel <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite <= 1'b1;
      csr_paddr <= {idx, 2'b00};
      csr_pwdata <= val;
      @(posedge clock);
      csr_penable <= 1'b1;
      @(posedge clock);
      csr_psel <= 1'b0;
      csr_penable <= 1'b0;
      case (idx)
         REG_LEFT:  box_left = longint'(signed'(val));
         REG_TOP:   box_top = longint'(signed'(val));
         REG_WIDTH: box_width = longint'(val & 32'h7FFF_FFFF);
         default:   box_height = longint'(val & 32'h7FFF_FFFF);
      endcase
   endtask

   task automatic set_box(logic [31:0] l, logic [31:0] t, logic [31:0] w, logic [31:0] h);
      // drop the input word so nothing more enters before the drain
      req_tvalid <= 1'b0;
      while (clip_expected.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      csr_write(REG_LEFT, l);
      csr_write(REG_TOP, t);
      csr_write(REG_WIDTH, w);
      csr_write(REG_HEIGHT, h);
   endtask

   // present one word, hold until taken, queue its expectation
   task automatic send_segment(bit kind, int sx, int sy, int ex, int ey, int unsigned rad,
                               clip_type expect_clip);
      int gap;
      req_tvalid <= 1'b1;
      req_tuser <= kind;
      req_tdata <= {1'b0, rad[30:0], ey, ex, sy, sx};
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      clip_expected.push_back(expect_clip);
      items_sent++;
      gap = pick_gap();
      if (gap > 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
   endtask

   // coordinate within a few box spans of the given edge
   function automatic int near(longint base, longint span);
      return int'(base + (longint'($urandom_range(0, 999)) * span) / 200 - 2 * span);
   endfunction

   task automatic random_segments(int count);
      longint span;
      int sx, sy, ex, ey, mode;
      int unsigned rad;
      bit kind;
      span = box_width > box_height ? box_width : box_height;
      if (span < U) span = U;
      for (int n = 0; n < count; n++) begin
         mode = $urandom_range(0, 99);
         kind = $urandom_range(0, 1);
         rad = (longint'($urandom_range(0, 999)) * span) / 2000;
         if ($urandom_range(0, 7) == 0) rad = $urandom;
         if (mode < 15) begin
            sx = $urandom; sy = $urandom; ex = $urandom; ey = $urandom;
         end else begin
            sx = near(box_left, span);
            sy = near(box_top, span);
            ex = near(box_left, span);
            ey = near(box_top, span);
            if (mode < 25) ey = sy;
            else if (mode < 35) ex = sx;
            else if (mode < 40) begin
               ex = sx;
               ey = sy;
            end
         end
         send_segment(kind, sx, sy, ex, ey, rad, predict_clip(kind, sx, sy, ex, ey, rad));
      end
   endtask

   row_type directed_rows[20] = '{
      '{0, 3*U, 3*U, 3*U, 3*U, 0, 1, 0, 0, 0, FACE_MIN_X},
      '{0, 5*U, 5*U, 20*U, 5*U, 0, 1, 0, 0, 0, FACE_MIN_X},
      '{0, -5*U, -U, 20*U, -U, 0, 1, 0, 0, 0, FACE_MIN_X},
      '{0, -5*U, 5*U, 5*U, 5*U, 0, 1, 1, 0, 5*U, FACE_MIN_X},
      '{0, 15*U, 5*U, 5*U, 5*U, 0, 0, 0, 0, 0, FACE_MIN_X},
      '{0, 5*U, -5*U, 5*U, 5*U, 0, 0, 0, 0, 0, FACE_MIN_X},
      '{0, 5*U, 15*U, 5*U, 5*U, 0, 0, 0, 0, 0, FACE_MIN_X},
      '{0, -5*U, -5*U, 5*U, 5*U, 0, 0, 0, 0, 0, FACE_MIN_X},
      '{0, 0, 5*U, 5*U, 5*U, 0, 0, 0, 0, 0, FACE_MIN_X},
      '{0, -5*U, 5*U, -U, 5*U, 0, 1, 0, 0, 0, FACE_MIN_X},
      '{1, -10*U, 5*U, 5*U, 5*U, 2*U, 0, 0, 0, 0, FACE_MIN_X},
      '{1, -10*U, 5*U, 5*U, 5*U, 32'h7FFF_FFFF, 0, 0, 0, 0, FACE_MIN_X},
      '{0, -5*U, 5*U, 5*U, 5*U, 32'h7FFF_FFFF, 1, 1, 0, 5*U, FACE_MIN_X},
      '{0, 32'h8000_0000, 32'h8000_0000, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 0, 0, 0, 0, 0,
        FACE_MIN_X},
      '{1, 32'h8000_0000, 32'h8000_0000, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 0, 0,
        0, 0, FACE_MIN_X},
      '{1, 32'h7FFF_FFFF, 32'h8000_0000, 32'h8000_0000, 32'h7FFF_FFFF, 12345, 0, 0, 0, 0,
        FACE_MIN_X},
      '{0, -5*U, 20*U, 20*U, 15*U, 0, 0, 0, 0, 0, FACE_MIN_X},
      '{1, 5*U, 30*U, 5*U, 0, 3*U, 0, 0, 0, 0, FACE_MIN_X},
      '{0, -5*U, 5*U, 30*U, 5*U, 0, 0, 0, 0, 0, FACE_MIN_X},
      '{1, -2*U, 5*U, 5*U, 5*U, 2*U, 0, 0, 0, 0, FACE_MIN_X}
   };

   // stimulus and phases
   initial begin
      clip_type typed_clip;
      box_left = 0; box_top = 0; box_width = 0; box_height = 0;
      repeat (9) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // directed part on a 10 x 10 box at the origin
      set_box(0, 0, 10*U, 10*U);
      foreach (directed_rows[i]) begin
         if (directed_rows[i].typed) begin
            typed_clip = '{hit: directed_rows[i].hit, px: directed_rows[i].px,
                           py: directed_rows[i].py, cx: directed_rows[i].px,
                           cy: directed_rows[i].py, face: directed_rows[i].face};
         end else begin
            typed_clip = predict_clip(directed_rows[i].kind, directed_rows[i].sx,
                                      directed_rows[i].sy, directed_rows[i].ex,
                                      directed_rows[i].ey, directed_rows[i].rad);
         end
         send_segment(directed_rows[i].kind, directed_rows[i].sx, directed_rows[i].sy,
                      directed_rows[i].ex, directed_rows[i].ey, directed_rows[i].rad,
                      typed_clip);
      end
      random_segments(300);

      // back to back, random moderate box
      idling_on = 1'b0;
      set_box(-($urandom_range(0, 64) * U), $urandom_range(0, 64) * U,
              $urandom_range(1, 100) * U, $urandom_range(1, 100) * U);
      random_segments(300);

      // largest box; width write checks truncation to 31 bits
      idling_on = 1'b1;
      set_box(32'h8000_0000, 32'h8000_0000, 32'hFFFF_FFFF, 32'h7FFF_FFFF);
      random_segments(250);

      // degenerate box at the top corner
      set_box(32'h7FFF_FFFF, 32'h7FFF_FFFF, 0, 0);
      random_segments(250);

      // fully random box
      set_box($urandom, $urandom, $urandom, $urandom);
      random_segments(300);

      // thin box, negative corner
      set_box(-1000*U, -3*U, 2000*U, U/4);
      random_segments(300);

      req_tvalid <= 1'b0;
      while (clip_expected.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      $display("Sent %0d segments, checked %0d results, %0d hits, over 6 box settings.",
               items_sent, words_checked, hits_seen);
      if (errors == 0) begin
         $display("All tests passed");
      end else begin
         $display("Some tests failed");
      end
      $finish;
   end

   // result checking, receiver stalls and watchdog
   int stall_left = 0;
   always @(posedge clock) begin
      clip_type want;
      clip_type got;
      if (!reset && rsp_tvalid && rsp_tready) begin
         got = '{hit: rsp_tuser, px: rsp_tdata[31:0], py: rsp_tdata[63:32],
                 cx: rsp_tdata[95:64], cy: rsp_tdata[127:96], face: rsp_tdata[129:128]};
         words_checked++;
         if (got.hit) hits_seen++;
         if (clip_expected.size() == 0) begin
            $error("result word with nothing expected");
            errors++;
         end else begin
            want = clip_expected.pop_front();
            if (got.hit !== want.hit) begin
               $error("hit: expected %0d got %0d", want.hit, got.hit); errors++;
            end
            if (got.px !== want.px) begin
               $error("point_x: expected %0d got %0d", want.px, got.px); errors++;
            end
            if (got.py !== want.py) begin
               $error("point_y: expected %0d got %0d", want.py, got.py); errors++;
            end
            if (got.cx !== want.cx) begin
               $error("center_x: expected %0d got %0d", want.cx, got.cx); errors++;
            end
            if (got.cy !== want.cy) begin
               $error("center_y: expected %0d got %0d", want.cy, got.cy); errors++;
            end
            if (got.face !== want.face) begin
               $error("face: expected %0d got %0d", want.face, got.face); errors++;
            end
         end
      end
      // stall the result side at random
      if (stall_left > 0) begin
         rsp_tready <= 1'b0;
         stall_left <= stall_left - 1;
      end else begin
         rsp_tready <= 1'b1;
         stall_left <= pick_gap();
      end
      // count cycles with no word moving on either side
      if (reset || (req_tvalid && req_tready) || (rsp_tvalid && rsp_tready)) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles >= WORD_LIMIT) begin
         $display("Timeout: no word moved for %0d cycles", WORD_LIMIT);
         $display("Some tests failed");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end
endmodule
